// ===== hw/rtl/atapio_pkg.sv =====
// ----------------------------------------------------------------------------
// ATA PIO read sequencer package
// Shared types, register map, status bits and result builders.
// ----------------------------------------------------------------------------
package atapio_pkg;

  localparam int unsigned WORDS_PER_SECTOR = 128;
  localparam int unsigned MAX_SECTORS      = 256;
  localparam int unsigned DWORD_W          = $clog2(WORDS_PER_SECTOR);
  localparam int unsigned RES_MAX          = 6;
  localparam int unsigned RES_CNT_W        = $clog2(RES_MAX + 1);

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_IO_BASE = 1'b1;

  localparam logic [19:0] TIMEOUT_RESET = 20'd1000000;
  localparam logic [15:0] IO_BASE_RESET = 16'h01F0;

  localparam logic [2:0] OFF_DATA    = 3'd0;
  localparam logic [2:0] OFF_COUNT   = 3'd2;
  localparam logic [2:0] OFF_LBA_LO  = 3'd3;
  localparam logic [2:0] OFF_LBA_MID = 3'd4;
  localparam logic [2:0] OFF_LBA_HI  = 3'd5;
  localparam logic [2:0] OFF_DRIVE   = 3'd6;
  localparam logic [2:0] OFF_CMDSTAT = 3'd7;

  localparam logic [7:0] DRIVE_LBA   = 8'hE0;
  localparam logic [7:0] CMD_READ    = 8'h20;
  localparam logic [3:0] LBA_TOP_MSK = 4'h0F;

  localparam int unsigned ST_ERR_BIT = 0;
  localparam int unsigned ST_DRQ_BIT = 3;
  localparam int unsigned ST_BSY_BIT = 7;

  localparam logic CMD_START    = 1'b0;
  localparam logic CMD_RESPONSE = 1'b1;

  typedef enum logic [1:0] {
    ACC_NONE       = 2'd0,
    ACC_BYTE_WRITE = 2'd1,
    ACC_BYTE_READ  = 2'd2,
    ACC_DWORD_READ = 2'd3
  } access_e;

  typedef enum logic [1:0] {
    RC_OK          = 2'd0,
    RC_BAD_COUNT   = 2'd1,
    RC_BSY_TIMEOUT = 2'd2,
    RC_DRQ_FAIL    = 2'd3
  } result_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_BSY   = 3'd1,
    PH_DUMMY = 3'd2,
    PH_DRQ   = 3'd3,
    PH_DATA  = 3'd4
  } phase_e;

  typedef struct packed {
    logic        command;
    logic [27:0] start_sector;
    logic [8:0]  sector_count;
    logic [31:0] read_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  access_kind;
    logic [15:0] port_address;
    logic [7:0]  write_byte;
    logic        data_valid;
    logic [31:0] data_word;
    logic [14:0] buffer_index;
    logic        done_res;
    logic [1:0]  result_code;
    logic        last;
  } out_word_t;

  typedef out_word_t [RES_MAX-1:0] res_list_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0] count;
    res_list_t            res;
  } bank_load_t;

  function automatic out_word_t res_access(access_e kind, logic [2:0] off,
                                           logic [7:0] wbyte, logic last,
                                           logic [15:0] base);
    out_word_t r;
    r              = '0;
    r.access_kind  = kind;
    r.port_address = base + {13'd0, off};
    r.write_byte   = wbyte;
    r.last         = last;
    return r;
  endfunction

  function automatic out_word_t res_data(logic [31:0] word, logic [14:0] idx,
                                         logic last);
    out_word_t r;
    r              = '0;
    r.data_valid   = 1'b1;
    r.data_word    = word;
    r.buffer_index = idx;
    r.last         = last;
    return r;
  endfunction

  function automatic out_word_t res_done(result_e code);
    out_word_t r;
    r             = '0;
    r.done_res    = 1'b1;
    r.result_code = code;
    r.last        = 1'b1;
    return r;
  endfunction

endpackage

// ===== hw/rtl/atapio_regs.sv =====
// ----------------------------------------------------------------------------
// ATA PIO configuration registers
// APB-style register file holding the poll limit and the I/O base port.
// ----------------------------------------------------------------------------
module atapio_regs import atapio_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [19:0]        timeout_o,
  output logic [15:0]        io_base_o
);

  logic [19:0] timeout_q;
  logic [15:0] io_base_q;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      io_base_q <= IO_BASE_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_TIMEOUT: timeout_q <= pwdata[19:0];
        REG_IO_BASE: io_base_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TIMEOUT: prdata = {12'd0, timeout_q};
      REG_IO_BASE: prdata = {16'd0, io_base_q};
      default:     prdata = '0;
    endcase
  end

  assign timeout_o = timeout_q;
  assign io_base_o = io_base_q;

endmodule

// ===== hw/rtl/atapio_ireg.sv =====
// ----------------------------------------------------------------------------
// ATA PIO input register
// Holds one accepted input word until the sequencer core takes it.
// ----------------------------------------------------------------------------
module atapio_ireg import atapio_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_word_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_word_t word_o
);

  logic     valid_q;
  logic     valid_d;
  in_word_t word_q;
  logic     accept;

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= in_word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== hw/rtl/atapio_core.sv =====
// ----------------------------------------------------------------------------
// ATA PIO sequencer core
// Protocol state and the decision logic that turns one input word into the
// list of bus accesses, data words and completion that it causes.
// ----------------------------------------------------------------------------
module atapio_core import atapio_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  in_word_t    word_i,
  input  logic [19:0] timeout_i,
  input  logic [15:0] io_base_i,
  output bank_load_t  load_o
);

  phase_e             phase_q, phase_d;
  logic [19:0]        poll_q, poll_d;
  logic [27:0]        sector_q, sector_d;
  logic [7:0]         count_q, count_d;
  logic [8:0]         left_q, left_d;
  logic [DWORD_W-1:0] dword_q, dword_d;
  logic [14:0]        bufpos_q, bufpos_d;
  logic               ignored_q, ignored_d;

  logic [7:0] st;
  logic       st_bsy;
  logic       st_drq;
  logic       st_err;
  logic       bad_count;
  logic       exhausted;
  logic       last_dword;
  logic       last_sector;
  logic       is_start;

  assign st          = word_i.read_value[7:0];
  assign st_bsy      = st[ST_BSY_BIT];
  assign st_drq      = st[ST_DRQ_BIT];
  assign st_err      = st[ST_ERR_BIT];
  assign is_start    = (word_i.command == CMD_START);
  assign bad_count   = (word_i.sector_count == 9'd0) ||
                       (word_i.sector_count > 9'(MAX_SECTORS));
  assign exhausted   = (poll_q >= timeout_i);
  assign last_dword  = (dword_q == DWORD_W'(WORDS_PER_SECTOR - 1));
  assign last_sector = (left_q == 9'd1);

  always_comb begin
    phase_d = phase_q;
    if (take_i) begin
      if (is_start) begin
        if (phase_q == PH_IDLE && !bad_count) begin
          phase_d = PH_BSY;
        end
      end else begin
        unique case (phase_q)
          PH_IDLE: ;
          PH_BSY: begin
            if (!st_bsy) begin
              phase_d = PH_DUMMY;
            end else if (exhausted) begin
              phase_d = PH_IDLE;
            end
          end
          PH_DUMMY: begin
            if (ignored_q) begin
              phase_d = PH_DRQ;
            end
          end
          PH_DRQ: begin
            if (st_err) begin
              phase_d = PH_IDLE;
            end else if (!st_bsy && st_drq) begin
              phase_d = PH_DATA;
            end else if (exhausted) begin
              phase_d = PH_IDLE;
            end
          end
          PH_DATA: begin
            if (last_dword) begin
              phase_d = last_sector ? PH_IDLE : PH_DRQ;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    load_o    = '0;
    poll_d    = poll_q;
    sector_d  = sector_q;
    count_d   = count_q;
    left_d    = left_q;
    dword_d   = dword_q;
    bufpos_d  = bufpos_q;
    ignored_d = ignored_q;
    if (take_i) begin
      if (is_start) begin
        if (phase_q == PH_IDLE) begin
          if (bad_count) begin
            load_o.count  = RES_CNT_W'(1);
            load_o.res[0] = res_done(RC_BAD_COUNT);
          end else begin
            sector_d      = word_i.start_sector;
            count_d       = word_i.sector_count[7:0];
            left_d        = word_i.sector_count;
            dword_d       = '0;
            bufpos_d      = '0;
            ignored_d     = 1'b0;
            poll_d        = 20'd1;
            load_o.count  = RES_CNT_W'(2);
            load_o.res[0] = res_access(ACC_BYTE_WRITE, OFF_DRIVE,
                                       DRIVE_LBA | {4'd0, word_i.start_sector[27:24] &
                                                    LBA_TOP_MSK},
                                       1'b0, io_base_i);
            load_o.res[1] = res_access(ACC_BYTE_READ, OFF_CMDSTAT, 8'd0, 1'b1, io_base_i);
          end
        end
      end else begin
        unique case (phase_q)
          PH_IDLE: ;
          PH_BSY: begin
            if (!st_bsy) begin
              ignored_d     = 1'b0;
              load_o.count  = RES_CNT_W'(6);
              load_o.res[0] = res_access(ACC_BYTE_WRITE, OFF_COUNT, count_q, 1'b0,
                                         io_base_i);
              load_o.res[1] = res_access(ACC_BYTE_WRITE, OFF_LBA_LO, sector_q[7:0], 1'b0,
                                         io_base_i);
              load_o.res[2] = res_access(ACC_BYTE_WRITE, OFF_LBA_MID, sector_q[15:8],
                                         1'b0, io_base_i);
              load_o.res[3] = res_access(ACC_BYTE_WRITE, OFF_LBA_HI, sector_q[23:16],
                                         1'b0, io_base_i);
              load_o.res[4] = res_access(ACC_BYTE_WRITE, OFF_CMDSTAT, CMD_READ, 1'b0,
                                         io_base_i);
              load_o.res[5] = res_access(ACC_BYTE_READ, OFF_CMDSTAT, 8'd0, 1'b1,
                                         io_base_i);
            end else if (exhausted) begin
              load_o.count  = RES_CNT_W'(1);
              load_o.res[0] = res_done(RC_BSY_TIMEOUT);
            end else begin
              poll_d        = poll_q + 20'd1;
              load_o.count  = RES_CNT_W'(1);
              load_o.res[0] = res_access(ACC_BYTE_READ, OFF_CMDSTAT, 8'd0, 1'b1,
                                         io_base_i);
            end
          end
          PH_DUMMY: begin
            load_o.count  = RES_CNT_W'(1);
            load_o.res[0] = res_access(ACC_BYTE_READ, OFF_CMDSTAT, 8'd0, 1'b1, io_base_i);
            ignored_d     = 1'b1;
            if (ignored_q) begin
              poll_d = 20'd1;
            end
          end
          PH_DRQ: begin
            load_o.count = RES_CNT_W'(1);
            if (st_err) begin
              load_o.res[0] = res_done(RC_DRQ_FAIL);
            end else if (!st_bsy && st_drq) begin
              dword_d       = '0;
              load_o.res[0] = res_access(ACC_DWORD_READ, OFF_DATA, 8'd0, 1'b1,
                                         io_base_i);
            end else if (exhausted) begin
              load_o.res[0] = res_done(RC_DRQ_FAIL);
            end else begin
              poll_d        = poll_q + 20'd1;
              load_o.res[0] = res_access(ACC_BYTE_READ, OFF_CMDSTAT, 8'd0, 1'b1,
                                         io_base_i);
            end
          end
          PH_DATA: begin
            load_o.count  = RES_CNT_W'(2);
            load_o.res[0] = res_data(word_i.read_value, bufpos_q, 1'b0);
            bufpos_d      = bufpos_q + 15'd1;
            if (last_dword) begin
              dword_d = '0;
              left_d  = left_q - 9'd1;
              if (last_sector) begin
                load_o.res[1] = res_done(RC_OK);
              end else begin
                poll_d        = 20'd1;
                load_o.res[1] = res_access(ACC_BYTE_READ, OFF_CMDSTAT, 8'd0, 1'b1,
                                           io_base_i);
              end
            end else begin
              dword_d       = dword_q + DWORD_W'(1);
              load_o.res[1] = res_access(ACC_DWORD_READ, OFF_DATA, 8'd0, 1'b1,
                                         io_base_i);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      poll_q    <= '0;
      sector_q  <= '0;
      count_q   <= '0;
      left_q    <= '0;
      dword_q   <= '0;
      bufpos_q  <= '0;
      ignored_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      poll_q    <= poll_d;
      sector_q  <= sector_d;
      count_q   <= count_d;
      left_q    <= left_d;
      dword_q   <= dword_d;
      bufpos_q  <= bufpos_d;
      ignored_q <= ignored_d;
    end
  end

endmodule

// ===== hw/rtl/atapio_obuf.sv =====
// ----------------------------------------------------------------------------
// ATA PIO result buffer
// Registered list of the words caused by one input word, shifted out one
// word per output handshake.
// ----------------------------------------------------------------------------
module atapio_obuf import atapio_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_en_i,
  input  bank_load_t load_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_word_o
);

  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  res_list_t            res_q, res_d;
  logic                 pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign free_o      = (cnt_q == '0) || ((cnt_q == RES_CNT_W'(1)) && pop);
  assign out_word_o  = res_q[0];

  always_comb begin
    cnt_d = cnt_q;
    res_d = res_q;
    if (load_en_i) begin
      cnt_d = load_i.count;
      res_d = load_i.res;
    end else if (pop) begin
      cnt_d = cnt_q - RES_CNT_W'(1);
      for (int i = 0; i < RES_MAX - 1; i++) begin
        res_d[i] = res_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

// ===== hw/rtl/ata_pio_lba28_read_sequencer.sv =====
// ----------------------------------------------------------------------------
// ATA PIO LBA28 read-sectors sequencer
// Host-side engine that issues the PIO read protocol one bus access at a time.
// ----------------------------------------------------------------------------
// The input channel carries start requests and the responses to bus reads.
// The output channel carries one word per bus access, sector dword or
// completion; the last word caused by an input word has last set. After
// each bus read the engine waits for its response as the next input word.
// An accepted input word waits in the input register until the result
// buffer is free, then the core writes its whole result list (up to six
// words) into the result buffer. The buffer sends one word per cycle while
// the receiver does not stall. A new input word is accepted while the
// previous results are still being sent. When the receiver stalls, the
// buffer holds its word and the input side stalls once the input register
// is full. Reset returns the engine to idle with cleared counters and the
// registers at their defaults (one million polls, base port 0x1F0). The
// user must see that registers are written only while the engine is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ata_pio_lba28_read_sequencer import atapio_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_word_t           in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_word_t          out_word_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic        timeout_unused;
  logic [19:0] timeout;
  logic [15:0] io_base;
  logic        stage_valid;
  in_word_t    stage_word;
  logic        buf_free;
  logic        take;
  bank_load_t  load;

  assign timeout_unused = 1'b0;
  assign take = stage_valid && buf_free && !timeout_unused;

  atapio_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .timeout_o (timeout),
    .io_base_o (io_base)
  );

  atapio_ireg u_ireg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .take_i     (take),
    .valid_o    (stage_valid),
    .word_o     (stage_word)
  );

  atapio_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .word_i    (stage_word),
    .timeout_i (timeout),
    .io_base_i (io_base),
    .load_o    (load)
  );

  atapio_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_en_i   (take),
    .load_i      (load),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== hw/rtl/atapio_checker.sv =====
// ----------------------------------------------------------------------------
// ATA PIO sequencer port checker
// Concurrent checks on the output channel of the read sequencer.
// ----------------------------------------------------------------------------
module atapio_checker import atapio_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input out_word_t out_word_i
);

  // A stalled word stays in place until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_word_i))
    else $error("output word changed while stalled");

  // A word without a bus access is either a data dword or a completion.
  a_no_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_word_i.access_kind == ACC_NONE) |->
      (out_word_i.data_valid || out_word_i.done_res))
    else $error("output word carries nothing");

  // Data and completion words never address a port.
  a_no_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_word_i.data_valid || out_word_i.done_res) |->
      (out_word_i.access_kind == ACC_NONE) && (out_word_i.port_address == 16'd0))
    else $error("data or completion word with a bus access");

  // Completion always closes the list of words for its input word.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.done_res |-> out_word_i.last && !out_word_i.data_valid)
    else $error("completion word is not the last word");

endmodule

bind ata_pio_lba28_read_sequencer atapio_checker u_atapio_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_i  (out_word_o)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the ATA PIO LBA28 read-sectors sequencer
// Acts as the drive: it answers every bus read of the engine with a status
// or data word, predicts each output word in step with the engine, and
// compares every word that leaves it. A directed table covers the bad counts,
// ignored words and status corner cases. Randomized requests follow, under
// several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import atapio_pkg::*;

  localparam int NUM_PHASES   = 5;
  localparam int BUDGET       = 35;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int END_CYCLES   = 20;
  localparam int LIMIT        = 400000;

  localparam logic [19:0] TIMEOUTS [NUM_PHASES] =
    '{TIMEOUT_RESET, 20'd0, 20'hFFFFF, 20'd1, 20'd3};
  localparam logic [15:0] BASES [NUM_PHASES] =
    '{IO_BASE_RESET, 16'hFFFF, 16'h0000, 16'h0170, 16'hFFF9};
  localparam int SND_PCT [NUM_PHASES] = '{0, 57, 0, 16, 0};
  localparam int RCV_PCT [NUM_PHASES] = '{0, 0, 57, 16, 0};

  typedef struct packed {
    logic        cmd;
    logic [27:0] sec;
    logic [8:0]  cnt;
    logic [31:0] val;
    logic        typed;
    logic        silent;
    result_e     code;
  } row_t;

  localparam row_t DIRECTED [20] = '{
    '{CMD_START,    28'h0000000, 9'd0,   32'h0000_0000, 1'b1, 1'b0, RC_BAD_COUNT},
    '{CMD_START,    28'hFFFFFFF, 9'd511, 32'hFFFF_FFFF, 1'b1, 1'b0, RC_BAD_COUNT},
    '{CMD_START,    28'hFFFFFFF, 9'd257, 32'h0000_0000, 1'b1, 1'b0, RC_BAD_COUNT},
    '{CMD_RESPONSE, 28'h0000000, 9'd0,   32'hFFFF_FFFF, 1'b1, 1'b1, RC_OK},
    '{CMD_START,    28'hFFFFFFF, 9'd256, 32'h0000_0000, 1'b0, 1'b0, RC_OK},
    '{CMD_START,    28'h0000000, 9'd1,   32'h0000_0000, 1'b1, 1'b1, RC_OK},
    '{CMD_RESPONSE, 28'h0000000, 9'd0,   32'h0000_0080, 1'b0, 1'b0, RC_OK},
    '{CMD_RESPONSE, 28'h0000000, 9'd0,   32'hFFFF_FF7F, 1'b0, 1'b0, RC_OK},
    '{CMD_RESPONSE, 28'hFFFFFFF, 9'd511, 32'hFFFF_FFFF, 1'b0, 1'b0, RC_OK},
    '{CMD_RESPONSE, 28'h0000000, 9'd0,   32'h0000_0000, 1'b0, 1'b0, RC_OK},
    '{CMD_RESPONSE, 28'h0000000, 9'd0,   32'h0000_0080, 1'b0, 1'b0, RC_OK},
    '{CMD_RESPONSE, 28'h0000000, 9'd0,   32'h0000_0088, 1'b0, 1'b0, RC_OK},
    '{CMD_RESPONSE, 28'h0000000, 9'd0,   32'h0000_0000, 1'b0, 1'b0, RC_OK},
    '{CMD_RESPONSE, 28'h0000000, 9'd0,   32'h0000_0009, 1'b1, 1'b0, RC_DRQ_FAIL},
    '{CMD_START,    28'h1234567, 9'd1,   32'h0000_0000, 1'b0, 1'b0, RC_OK},
    '{CMD_RESPONSE, 28'h0000000, 9'd0,   32'h0000_0000, 1'b0, 1'b0, RC_OK},
    '{CMD_RESPONSE, 28'h0000000, 9'd0,   32'hA5A5_A5A5, 1'b0, 1'b0, RC_OK},
    '{CMD_RESPONSE, 28'h0000000, 9'd0,   32'h5A5A_5A5A, 1'b0, 1'b0, RC_OK},
    '{CMD_RESPONSE, 28'h0000000, 9'd0,   32'h0000_0001, 1'b1, 1'b0, RC_DRQ_FAIL},
    '{CMD_START,    28'h0ABCDEF, 9'd1,   32'h0000_0000, 1'b0, 1'b0, RC_OK}
  };

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_word_t           in_word   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_word;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  ata_pio_lba28_read_sequencer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Engine state as the drive side sees it.
  phase_e      eng_phase   = PH_IDLE;
  logic [19:0] eng_polls   = '0;
  logic [27:0] eng_sector  = '0;
  logic [8:0]  eng_count   = '0;
  logic [8:0]  eng_left    = '0;
  logic [6:0]  eng_dword   = '0;
  logic [14:0] eng_bufpos  = '0;
  logic [1:0]  eng_dummy   = '0;
  logic [19:0] eng_timeout = TIMEOUT_RESET;
  logic [15:0] eng_base    = IO_BASE_RESET;

  out_word_t words_due [$];
  out_word_t step_words [$];

  int  n_err       = 0;
  int  n_in        = 0;
  int  n_out       = 0;
  int  cycle_count = 0;
  int  ends_seen [4] = '{0, 0, 0, 0};
  int  snd_pct     = 0;
  int  rcv_pct     = 0;
  bit  hold_req    = 1'b0;
  bit  clean       = 1'b0;
  bit  clean_used  = 1'b0;

  function automatic out_word_t done_word(result_e code);
    out_word_t r;
    r             = '0;
    r.done_res    = 1'b1;
    r.result_code = code;
    r.last        = 1'b1;
    return r;
  endfunction

  function automatic void push_access(access_e kind, logic [2:0] off, logic [7:0] b);
    out_word_t r;
    r              = '0;
    r.access_kind  = kind;
    r.port_address = eng_base + 16'(off);
    r.write_byte   = b;
    step_words.push_back(r);
  endfunction

  function automatic void push_data(logic [31:0] word, logic [14:0] idx);
    out_word_t r;
    r              = '0;
    r.data_valid   = 1'b1;
    r.data_word    = word;
    r.buffer_index = idx;
    step_words.push_back(r);
  endfunction

  function automatic void end_request(result_e code);
    eng_phase = PH_IDLE;
    step_words.push_back(done_word(code));
  endfunction

  function automatic void engine_step(in_word_t w);
    logic [7:0] st;
    st = w.read_value[7:0];
    step_words.delete();
    if (w.command == CMD_START) begin
      if (eng_phase == PH_IDLE) begin
        if (w.sector_count == 9'd0 || w.sector_count > 9'(MAX_SECTORS)) begin
          end_request(RC_BAD_COUNT);
        end else begin
          eng_sector = w.start_sector;
          eng_count  = w.sector_count;
          eng_left   = w.sector_count;
          eng_dword  = '0;
          eng_bufpos = '0;
          eng_dummy  = '0;
          push_access(ACC_BYTE_WRITE, OFF_DRIVE,
                      DRIVE_LBA | {4'h0, w.start_sector[27:24] & LBA_TOP_MSK});
          push_access(ACC_BYTE_READ, OFF_CMDSTAT, 8'h00);
          eng_polls = 20'd1;
          eng_phase = PH_BSY;
        end
      end
    end else begin
      case (eng_phase)
        PH_BSY: begin
          if (!st[ST_BSY_BIT]) begin
            push_access(ACC_BYTE_WRITE, OFF_COUNT, eng_count[7:0]);
            push_access(ACC_BYTE_WRITE, OFF_LBA_LO, eng_sector[7:0]);
            push_access(ACC_BYTE_WRITE, OFF_LBA_MID, eng_sector[15:8]);
            push_access(ACC_BYTE_WRITE, OFF_LBA_HI, eng_sector[23:16]);
            push_access(ACC_BYTE_WRITE, OFF_CMDSTAT, CMD_READ);
            push_access(ACC_BYTE_READ, OFF_CMDSTAT, 8'h00);
            eng_dummy = '0;
            eng_phase = PH_DUMMY;
          end else if (eng_polls >= eng_timeout) begin
            end_request(RC_BSY_TIMEOUT);
          end else begin
            push_access(ACC_BYTE_READ, OFF_CMDSTAT, 8'h00);
            eng_polls = eng_polls + 20'd1;
          end
        end
        PH_DUMMY: begin
          push_access(ACC_BYTE_READ, OFF_CMDSTAT, 8'h00);
          if (eng_dummy == 2'd0) begin
            eng_dummy = 2'd1;
          end else begin
            eng_dummy = 2'd2;
            eng_polls = 20'd1;
            eng_phase = PH_DRQ;
          end
        end
        PH_DRQ: begin
          if (st[ST_ERR_BIT]) begin
            end_request(RC_DRQ_FAIL);
          end else if (!st[ST_BSY_BIT] && st[ST_DRQ_BIT]) begin
            push_access(ACC_DWORD_READ, OFF_DATA, 8'h00);
            eng_dword = '0;
            eng_phase = PH_DATA;
          end else if (eng_polls >= eng_timeout) begin
            end_request(RC_DRQ_FAIL);
          end else begin
            push_access(ACC_BYTE_READ, OFF_CMDSTAT, 8'h00);
            eng_polls = eng_polls + 20'd1;
          end
        end
        PH_DATA: begin
          push_data(w.read_value, eng_bufpos);
          eng_bufpos = eng_bufpos + 15'd1;
          if (eng_dword == 7'(WORDS_PER_SECTOR - 1)) begin
            eng_dword = '0;
            eng_left  = eng_left - 9'd1;
            if (eng_left == 9'd0) begin
              end_request(RC_OK);
            end else begin
              push_access(ACC_BYTE_READ, OFF_CMDSTAT, 8'h00);
              eng_polls = 20'd1;
              eng_phase = PH_DRQ;
            end
          end else begin
            eng_dword = eng_dword + 7'd1;
            push_access(ACC_DWORD_READ, OFF_DATA, 8'h00);
          end
        end
        default: ;
      endcase
    end
    if (step_words.size() > 0) step_words[$].last = 1'b1;
  endfunction

  // Picks the drive's next word from the engine's predicted phase. A clean
  // request always gets good status so that it runs to a full sector.
  function automatic in_word_t plan_word(bit closing, output bit noise);
    in_word_t   w;
    logic [7:0] st;
    int         pick;
    w.command      = CMD_RESPONSE;
    w.start_sector = 28'($urandom);
    w.sector_count = 9'($urandom);
    w.read_value   = $urandom;
    noise = ($urandom_range(99) < 5);
    if (noise) begin
      w.command = (eng_phase == PH_IDLE) ? CMD_RESPONSE : CMD_START;
      return w;
    end
    st   = w.read_value[7:0];
    pick = $urandom_range(99);
    case (eng_phase)
      PH_IDLE: begin
        w.command = CMD_START;
        if (clean && clean_used) clean = 1'b0;
        clean_used = 1'b1;
        if (pick < 10) w.start_sector = (pick < 5) ? '0 : '1;
        pick = $urandom_range(99);
        if (clean)          w.sector_count = 9'd1;
        else if (pick < 5)  w.sector_count = 9'd0;
        else if (pick < 12) w.sector_count = 9'($urandom_range(257, 511));
        else if (pick < 60) w.sector_count = 9'd1;
        else if (pick < 75) w.sector_count = 9'd2;
        else if (pick < 92) w.sector_count = 9'($urandom_range(3, 255));
        else                w.sector_count = 9'(MAX_SECTORS);
      end
      PH_BSY: st[ST_BSY_BIT] = !(clean || closing) && pick < 50;
      PH_DRQ: begin
        if (clean || (!closing && pick < 25)) begin
          st[ST_BSY_BIT] = 1'b0;
          st[ST_DRQ_BIT] = 1'b1;
          st[ST_ERR_BIT] = 1'b0;
        end else if (closing || pick < 40) begin
          st[ST_ERR_BIT] = 1'b1;
        end else begin
          st[ST_ERR_BIT] = 1'b0;
          if (pick < 70) st[ST_BSY_BIT] = 1'b1;
          else           st[ST_DRQ_BIT] = 1'b0;
        end
      end
      default: ;
    endcase
    w.read_value[7:0] = st;
    return w;
  endfunction

  task automatic send_word(in_word_t w, bit keep);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall);
    n_in++;
    engine_step(w);
    if (keep) begin
      foreach (step_words[i]) words_due.push_back(step_words[i]);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (words_due.size() != 0);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_TIMEOUT) eng_timeout = value[19:0];
    else                    eng_base    = value[15:0];
  endtask

  function automatic void cmp_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      n_err++;
    end
  endfunction

  task automatic check_word(out_word_t got);
    out_word_t want;
    if (words_due.size() == 0) begin
      $error("word with nothing expected: %h", got);
      n_err++;
      return;
    end
    want = words_due.pop_front();
    n_out++;
    if (want.done_res) ends_seen[want.result_code]++;
    cmp_field("access_kind", want.access_kind, got.access_kind);
    cmp_field("port_address", want.port_address, got.port_address);
    cmp_field("write_byte", want.write_byte, got.write_byte);
    cmp_field("data_valid", want.data_valid, got.data_valid);
    cmp_field("data_word", want.data_word, got.data_word);
    cmp_field("buffer_index", want.buffer_index, got.buffer_index);
    cmp_field("done_res", want.done_res, got.done_res);
    cmp_field("result_code", want.result_code, got.result_code);
    cmp_field("last", want.last, got.last);
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && !out_stall) check_word(out_word);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (rcv_pct > 0) && ($urandom_range(99) < rcv_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    in_word_t w;
    bit       noise;
    bit       counted;
    bit       paused;
    int       used;
    paused = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      w.command      = DIRECTED[i].cmd;
      w.start_sector = DIRECTED[i].sec;
      w.sector_count = DIRECTED[i].cnt;
      w.read_value   = DIRECTED[i].val;
      send_word(w, !DIRECTED[i].typed);
      if (DIRECTED[i].typed && !DIRECTED[i].silent)
        words_due.push_back(done_word(DIRECTED[i].code));
    end

    // Data dwords ride along with a request and do not count toward the budget.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk_i);
        write_reg(REG_TIMEOUT, {12'd0, TIMEOUTS[p]});
        write_reg(REG_IO_BASE, {16'd0, BASES[p]});
      end
      snd_pct    = SND_PCT[p];
      rcv_pct    = RCV_PCT[p];
      clean      = 1'b1;
      clean_used = (p == 0);
      if (p == 0) hold_req = 1'b1;
      used = 0;
      forever begin
        if (eng_phase == PH_IDLE && used >= BUDGET) break;
        if (p == 2 && !paused && used >= BUDGET / 2) begin
          drain();
          paused = 1'b1;
        end
        w       = plan_word(used >= BUDGET, noise);
        counted = !noise && eng_phase != PH_DATA;
        send_word(w, 1'b1);
        if (counted) used++;
      end
    end

    drain();
    repeat (END_CYCLES) @(posedge clk_i);
    $display("Checked %0d output words from %0d input words over %0d setting phases.",
             n_out, n_in, NUM_PHASES);
    $display("Requests ended: %0d ok, %0d bad count, %0d busy timeout, %0d data wait fail.",
             ends_seen[RC_OK], ends_seen[RC_BAD_COUNT], ends_seen[RC_BSY_TIMEOUT],
             ends_seen[RC_DRQ_FAIL]);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/atapio_pkg.sv
hw/rtl/atapio_regs.sv
hw/rtl/atapio_ireg.sv
hw/rtl/atapio_core.sv
hw/rtl/atapio_obuf.sv
hw/rtl/ata_pio_lba28_read_sequencer.sv
hw/rtl/atapio_checker.sv
dv/tb_top.sv
